### rtl/core/mra_pkg.sv
// ----------------------------------------------------------------------------
// mra_pkg
// shared types, constants and helpers of the maxrects rectangle allocator
// ----------------------------------------------------------------------------
package mra_pkg;

    localparam int MAX_FREE_RECTS = 256;
    localparam int MAX_NEW_RECTS  = 64;
    localparam int FREE_AW        = $clog2(MAX_FREE_RECTS);
    localparam int FREE_CW        = FREE_AW + 1;
    localparam int NEW_AW         = $clog2(MAX_NEW_RECTS);
    localparam int NEW_CW         = NEW_AW + 1;
    localparam int DIM_W          = 13;
    localparam int POS_W          = 12;
    localparam int SUM_W          = DIM_W + 1;
    localparam int AREA_W         = 2 * DIM_W;
    localparam int RULE_W         = 2;
    localparam int CFG_AW         = 4;
    localparam int APB_DW         = 32;

    localparam logic [DIM_W-1:0] BIN_RESET = DIM_W'(1024);
    localparam logic [DIM_W-1:0] DIM_MAX   = DIM_W'(4096);

    typedef enum logic [RULE_W-1:0] {
        RULE_SHORT = 2'd0,
        RULE_LONG  = 2'd1,
        RULE_AREA  = 2'd2,
        RULE_BL    = 2'd3
    } fit_rule_t;

    typedef enum logic [1:0] {
        REG_BIN_WIDTH  = 2'd0,
        REG_BIN_HEIGHT = 2'd1,
        REG_FIT_RULE   = 2'd2
    } reg_idx_t;

    typedef enum logic {
        CMD_CLEAR = 1'b0,
        CMD_PLACE = 1'b1
    } cmd_t;

    typedef struct packed {
        logic [DIM_W-1:0] x;
        logic [DIM_W-1:0] y;
        logic [DIM_W-1:0] w;
        logic [DIM_W-1:0] h;
    } box_t;

    typedef enum logic [1:0] {
        FW_CLEAR = 2'd0,
        FW_MOVE  = 2'd1,
        FW_NEW   = 2'd2
    } fw_src_t;

    typedef enum logic {
        NW_MOVE  = 1'b0,
        NW_PIECE = 1'b1
    } nw_src_t;

    typedef enum logic [4:0] {
        ST_INIT, ST_IDLE, ST_CLEAR,
        ST_SCAN_RD, ST_SCAN_S1, ST_SCAN_S2, ST_SCAN_END,
        ST_SPL_RD, ST_SPL_LD, ST_SPL_TST, ST_PC_SEL,
        ST_AP_RD, ST_AP_TST, ST_AP_M1, ST_AP_M2, ST_AP_M3, ST_AP_M4,
        ST_SPL_MV1, ST_SPL_MV2,
        ST_PR_RD, ST_PR_LD, ST_PR_NRD, ST_PR_TST, ST_PR_M1, ST_PR_M2,
        ST_MG_RD, ST_MG_WR, ST_DONE
    } state_t;

    typedef struct packed {
        logic               req_load;
        logic [FREE_AW-1:0] f_raddr;
        logic               f_we;
        logic [FREE_AW-1:0] f_waddr;
        fw_src_t            f_wsrc;
        logic [NEW_AW-1:0]  n_raddr;
        logic               n_we;
        logic [NEW_AW-1:0]  n_waddr;
        nw_src_t            n_wsrc;
        logic               scan_start;
        logic               scan_s1;
        logic               scan_s2;
        logic               f_load;
        logic               piece_load;
        logic [1:0]         piece_sel;
    } ctrl_cmd_t;

    typedef struct packed {
        logic             found;
        logic             overlap;
        logic [3:0]       piece_en;
        logic             piece_in_new;
        logic             new_in_piece;
        logic             new_in_free;
        logic [DIM_W-1:0] best_x;
        logic [DIM_W-1:0] best_y;
    } dp_stat_t;

    typedef struct packed {
        logic push;
        logic placed;
        logic overflow;
    } res_t;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        r = v;
        if (v == '0)
        begin
            r = DIM_W'(1);
        end
        else if (v > DIM_MAX)
        begin
            r = DIM_MAX;
        end
        return r;
    endfunction

    // a lies within b
    function automatic logic box_in(input box_t a, input box_t b);
        logic [SUM_W-1:0] ax2;
        logic [SUM_W-1:0] ay2;
        logic [SUM_W-1:0] bx2;
        logic [SUM_W-1:0] by2;
        ax2 = {1'b0, a.x} + {1'b0, a.w};
        ay2 = {1'b0, a.y} + {1'b0, a.h};
        bx2 = {1'b0, b.x} + {1'b0, b.w};
        by2 = {1'b0, b.y} + {1'b0, b.h};
        return (a.x >= b.x) && (a.y >= b.y) && (ax2 <= bx2) && (ay2 <= by2);
    endfunction

endpackage

### rtl/core/mra_datapath.sv
// ----------------------------------------------------------------------------
// mra_datapath
// free and new rectangle memories, fit scoring, split pieces, containment
// ----------------------------------------------------------------------------
module mra_datapath (
    input  logic                             clk,
    input  logic                             rst_n,
    input  mra_pkg::ctrl_cmd_t               cmd,
    input  logic [mra_pkg::DIM_W-1:0]        rect_width,
    input  logic [mra_pkg::DIM_W-1:0]        rect_height,
    input  logic [mra_pkg::DIM_W-1:0]        bin_width,
    input  logic [mra_pkg::DIM_W-1:0]        bin_height,
    input  logic [mra_pkg::RULE_W-1:0]       fit_rule,
    output mra_pkg::dp_stat_t                stat
);

    mra_pkg::box_t fmem [mra_pkg::MAX_FREE_RECTS];
    mra_pkg::box_t nmem [mra_pkg::MAX_NEW_RECTS];

    mra_pkg::box_t f_rd_reg;
    mra_pkg::box_t n_rd_reg;
    mra_pkg::box_t f_reg;
    mra_pkg::box_t piece_reg;
    mra_pkg::box_t f_wdata;
    mra_pkg::box_t n_wdata;
    mra_pkg::box_t pieces [4];

    logic [mra_pkg::DIM_W-1:0]  req_w_reg;
    logic [mra_pkg::DIM_W-1:0]  req_h_reg;
    logic [mra_pkg::AREA_W-1:0] wh_reg;

    logic                       fit_reg;
    logic [mra_pkg::DIM_W-1:0]  mn_reg;
    logic [mra_pkg::DIM_W-1:0]  mx_reg;
    logic [mra_pkg::AREA_W-1:0] area_reg;
    logic [mra_pkg::SUM_W-1:0]  yh_reg;
    logic [mra_pkg::DIM_W-1:0]  sx_reg;
    logic [mra_pkg::DIM_W-1:0]  sy_reg;

    logic                       found_reg;
    logic [mra_pkg::AREA_W-1:0] b1_reg;
    logic [mra_pkg::DIM_W-1:0]  b2_reg;
    logic [mra_pkg::DIM_W-1:0]  best_x_reg;
    logic [mra_pkg::DIM_W-1:0]  best_y_reg;

    logic                       fit_c;
    logic [mra_pkg::DIM_W-1:0]  lh;
    logic [mra_pkg::DIM_W-1:0]  lv;
    logic [mra_pkg::AREA_W-1:0] s1;
    logic [mra_pkg::DIM_W-1:0]  s2;
    logic                       better;

    logic [mra_pkg::SUM_W-1:0]  ux2;
    logic [mra_pkg::SUM_W-1:0]  uy2;
    logic [mra_pkg::SUM_W-1:0]  fx2;
    logic [mra_pkg::SUM_W-1:0]  fy2;
    logic [mra_pkg::SUM_W-1:0]  dh1;
    logic [mra_pkg::SUM_W-1:0]  dw3;

    // memories
    always_ff @(posedge clk)
    begin
        f_rd_reg <= fmem[cmd.f_raddr];
        n_rd_reg <= nmem[cmd.n_raddr];
        if (cmd.f_we)
        begin
            fmem[cmd.f_waddr] <= f_wdata;
        end
        if (cmd.n_we)
        begin
            nmem[cmd.n_waddr] <= n_wdata;
        end
    end

    always_comb
    begin
        case (cmd.f_wsrc)
            mra_pkg::FW_CLEAR: f_wdata = '{x: '0, y: '0,
                                           w: mra_pkg::clamp_dim(bin_width),
                                           h: mra_pkg::clamp_dim(bin_height)};
            mra_pkg::FW_MOVE:  f_wdata = f_rd_reg;
            default:           f_wdata = n_rd_reg;
        endcase
        n_wdata = (cmd.n_wsrc == mra_pkg::NW_PIECE) ? piece_reg : n_rd_reg;
    end

    // split pieces of f_reg around the placed rectangle
    always_comb
    begin
        ux2 = {1'b0, best_x_reg} + {1'b0, req_w_reg};
        uy2 = {1'b0, best_y_reg} + {1'b0, req_h_reg};
        fx2 = {1'b0, f_reg.x} + {1'b0, f_reg.w};
        fy2 = {1'b0, f_reg.y} + {1'b0, f_reg.h};
        dh1 = fy2 - uy2;
        dw3 = fx2 - ux2;
        pieces[0] = '{x: f_reg.x, y: f_reg.y, w: f_reg.w, h: best_y_reg - f_reg.y};
        pieces[1] = '{x: f_reg.x, y: uy2[mra_pkg::DIM_W-1:0], w: f_reg.w,
                      h: dh1[mra_pkg::DIM_W-1:0]};
        pieces[2] = '{x: f_reg.x, y: f_reg.y, w: best_x_reg - f_reg.x, h: f_reg.h};
        pieces[3] = '{x: ux2[mra_pkg::DIM_W-1:0], y: f_reg.y,
                      w: dw3[mra_pkg::DIM_W-1:0], h: f_reg.h};
        stat.overlap = !(({1'b0, best_x_reg} >= fx2) || (ux2 <= {1'b0, f_reg.x}) ||
                         ({1'b0, best_y_reg} >= fy2) || (uy2 <= {1'b0, f_reg.y}));
        stat.piece_en[0] = (best_y_reg > f_reg.y) && ({1'b0, best_y_reg} < fy2);
        stat.piece_en[1] = (uy2 < fy2);
        stat.piece_en[2] = (best_x_reg > f_reg.x) && ({1'b0, best_x_reg} < fx2);
        stat.piece_en[3] = (ux2 < fx2);
        stat.piece_in_new = mra_pkg::box_in(piece_reg, n_rd_reg);
        stat.new_in_piece = mra_pkg::box_in(n_rd_reg, piece_reg);
        stat.new_in_free  = mra_pkg::box_in(n_rd_reg, f_reg);
        stat.found        = found_reg;
        stat.best_x       = best_x_reg;
        stat.best_y       = best_y_reg;
    end

    // scoring
    always_comb
    begin
        fit_c = (f_rd_reg.w >= req_w_reg) && (f_rd_reg.h >= req_h_reg);
        lh    = f_rd_reg.w - req_w_reg;
        lv    = f_rd_reg.h - req_h_reg;
        case (mra_pkg::fit_rule_t'(fit_rule))
            mra_pkg::RULE_SHORT:
            begin
                s1 = mra_pkg::AREA_W'(mn_reg);
                s2 = mx_reg;
            end
            mra_pkg::RULE_LONG:
            begin
                s1 = mra_pkg::AREA_W'(mx_reg);
                s2 = mn_reg;
            end
            mra_pkg::RULE_AREA:
            begin
                s1 = area_reg - wh_reg;
                s2 = mn_reg;
            end
            default:
            begin
                s1 = mra_pkg::AREA_W'(yh_reg);
                s2 = sx_reg;
            end
        endcase
        better = fit_reg && (!found_reg || (s1 < b1_reg) || ((s1 == b1_reg) && (s2 < b2_reg)));
    end

    always_ff @(posedge clk)
    begin
        if (cmd.req_load)
        begin
            req_w_reg <= rect_width;
            req_h_reg <= rect_height;
            wh_reg    <= mra_pkg::AREA_W'(rect_width) * mra_pkg::AREA_W'(rect_height);
        end
        if (cmd.scan_s1)
        begin
            fit_reg  <= fit_c;
            mn_reg   <= (lh < lv) ? lh : lv;
            mx_reg   <= (lh < lv) ? lv : lh;
            area_reg <= mra_pkg::AREA_W'(f_rd_reg.w) * mra_pkg::AREA_W'(f_rd_reg.h);
            yh_reg   <= {1'b0, f_rd_reg.y} + {1'b0, req_h_reg};
            sx_reg   <= f_rd_reg.x;
            sy_reg   <= f_rd_reg.y;
        end
        if (cmd.scan_s2 && better)
        begin
            b1_reg     <= s1;
            b2_reg     <= s2;
            best_x_reg <= sx_reg;
            best_y_reg <= sy_reg;
        end
        if (cmd.f_load)
        begin
            f_reg <= f_rd_reg;
        end
        if (cmd.piece_load)
        begin
            piece_reg <= pieces[cmd.piece_sel];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
        end
        else if (cmd.scan_start)
        begin
            found_reg <= 1'b0;
        end
        else if (cmd.scan_s2 && better)
        begin
            found_reg <= 1'b1;
        end
    end

endmodule

### rtl/core/mra_controller.sv
// ----------------------------------------------------------------------------
// mra_controller
// sequencer for clear, scan, split, prune and merge passes over the rectangle stores
// ----------------------------------------------------------------------------
module mra_controller (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_cmd,
    input  logic                in_h_zero,
    input  logic                out_free,
    input  mra_pkg::dp_stat_t   stat,
    output logic                in_ready,
    output mra_pkg::ctrl_cmd_t  cmd,
    output mra_pkg::res_t       res
);

    mra_pkg::state_t state_reg, state_next;

    logic [mra_pkg::FREE_CW-1:0] i_reg, i_next;
    logic [mra_pkg::FREE_CW-1:0] fc_reg, fc_next;
    logic [mra_pkg::NEW_CW-1:0]  j_reg, j_next;
    logic [mra_pkg::NEW_CW-1:0]  nc_reg, nc_next;
    logic [mra_pkg::NEW_CW-1:0]  nchk_reg, nchk_next;
    logic [2:0]                  k_reg, k_next;
    logic                        dropped_reg, dropped_next;
    logic                        placed_reg, placed_next;
    logic [mra_pkg::FREE_CW-1:0] fc_m1;
    logic [mra_pkg::NEW_CW-1:0]  nc_m1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= mra_pkg::ST_INIT;
            i_reg       <= '0;
            fc_reg      <= '0;
            j_reg       <= '0;
            nc_reg      <= '0;
            nchk_reg    <= '0;
            k_reg       <= '0;
            dropped_reg <= 1'b0;
            placed_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            i_reg       <= i_next;
            fc_reg      <= fc_next;
            j_reg       <= j_next;
            nc_reg      <= nc_next;
            nchk_reg    <= nchk_next;
            k_reg       <= k_next;
            dropped_reg <= dropped_next;
            placed_reg  <= placed_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        i_next       = i_reg;
        fc_next      = fc_reg;
        j_next       = j_reg;
        nc_next      = nc_reg;
        nchk_next    = nchk_reg;
        k_next       = k_reg;
        dropped_next = dropped_reg;
        placed_next  = placed_reg;
        fc_m1        = fc_reg - mra_pkg::FREE_CW'(1);
        nc_m1        = nc_reg - mra_pkg::NEW_CW'(1);
        in_ready     = 1'b0;
        res.push     = 1'b0;
        res.placed   = placed_reg;
        res.overflow = dropped_reg;
        cmd          = '0;
        cmd.f_wsrc   = mra_pkg::FW_CLEAR;
        cmd.n_wsrc   = mra_pkg::NW_MOVE;
        cmd.f_raddr  = i_reg[mra_pkg::FREE_AW-1:0];
        cmd.n_raddr  = j_reg[mra_pkg::NEW_AW-1:0];
        cmd.f_waddr  = i_reg[mra_pkg::FREE_AW-1:0];
        cmd.n_waddr  = j_reg[mra_pkg::NEW_AW-1:0];
        cmd.piece_sel = k_reg[1:0];

        unique case (state_reg)
            mra_pkg::ST_INIT, mra_pkg::ST_CLEAR:
            begin
                cmd.f_we    = 1'b1;
                cmd.f_waddr = '0;
                cmd.f_wsrc  = mra_pkg::FW_CLEAR;
                fc_next     = mra_pkg::FREE_CW'(1);
                nc_next     = '0;
                nchk_next   = '0;
                placed_next = 1'b0;
                state_next  = (state_reg == mra_pkg::ST_INIT) ? mra_pkg::ST_IDLE
                                                              : mra_pkg::ST_DONE;
            end
            mra_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.req_load = 1'b1;
                    dropped_next = 1'b0;
                    placed_next  = 1'b0;
                    i_next       = '0;
                    if (mra_pkg::cmd_t'(in_cmd) == mra_pkg::CMD_CLEAR)
                    begin
                        state_next = mra_pkg::ST_CLEAR;
                    end
                    else if (in_h_zero)
                    begin
                        state_next = mra_pkg::ST_DONE;
                    end
                    else
                    begin
                        cmd.scan_start = 1'b1;
                        state_next     = mra_pkg::ST_SCAN_RD;
                    end
                end
            end
            mra_pkg::ST_SCAN_RD:
            begin
                state_next = (i_reg < fc_reg) ? mra_pkg::ST_SCAN_S1 : mra_pkg::ST_SCAN_END;
            end
            mra_pkg::ST_SCAN_S1:
            begin
                cmd.scan_s1 = 1'b1;
                state_next  = mra_pkg::ST_SCAN_S2;
            end
            mra_pkg::ST_SCAN_S2:
            begin
                cmd.scan_s2 = 1'b1;
                i_next      = i_reg + mra_pkg::FREE_CW'(1);
                state_next  = mra_pkg::ST_SCAN_RD;
            end
            mra_pkg::ST_SCAN_END:
            begin
                i_next = '0;
                if (stat.found)
                begin
                    placed_next = 1'b1;
                    state_next  = mra_pkg::ST_SPL_RD;
                end
                else
                begin
                    state_next = mra_pkg::ST_DONE;
                end
            end
            mra_pkg::ST_SPL_RD:
            begin
                if (i_reg < fc_reg)
                begin
                    state_next = mra_pkg::ST_SPL_LD;
                end
                else
                begin
                    i_next     = '0;
                    state_next = mra_pkg::ST_PR_RD;
                end
            end
            mra_pkg::ST_SPL_LD:
            begin
                cmd.f_load = 1'b1;
                state_next = mra_pkg::ST_SPL_TST;
            end
            mra_pkg::ST_SPL_TST:
            begin
                if (stat.overlap)
                begin
                    nchk_next  = nc_reg;
                    k_next     = '0;
                    state_next = mra_pkg::ST_PC_SEL;
                end
                else
                begin
                    i_next     = i_reg + mra_pkg::FREE_CW'(1);
                    state_next = mra_pkg::ST_SPL_RD;
                end
            end
            mra_pkg::ST_PC_SEL:
            begin
                if (k_reg[2])
                begin
                    state_next = mra_pkg::ST_SPL_MV1;
                end
                else if (stat.piece_en[k_reg[1:0]])
                begin
                    cmd.piece_load = 1'b1;
                    j_next         = '0;
                    state_next     = mra_pkg::ST_AP_RD;
                end
                else
                begin
                    k_next = k_reg + 3'd1;
                end
            end
            mra_pkg::ST_AP_RD:
            begin
                if ((j_reg < nchk_reg) && (j_reg < nc_reg))
                begin
                    state_next = mra_pkg::ST_AP_TST;
                end
                else
                begin
                    if (nc_reg < mra_pkg::NEW_CW'(mra_pkg::MAX_NEW_RECTS))
                    begin
                        cmd.n_we    = 1'b1;
                        cmd.n_waddr = nc_reg[mra_pkg::NEW_AW-1:0];
                        cmd.n_wsrc  = mra_pkg::NW_PIECE;
                        nc_next     = nc_reg + mra_pkg::NEW_CW'(1);
                    end
                    else
                    begin
                        dropped_next = 1'b1;
                    end
                    k_next     = k_reg + 3'd1;
                    state_next = mra_pkg::ST_PC_SEL;
                end
            end
            mra_pkg::ST_AP_TST:
            begin
                if (stat.piece_in_new)
                begin
                    k_next     = k_reg + 3'd1;
                    state_next = mra_pkg::ST_PC_SEL;
                end
                else if (stat.new_in_piece)
                begin
                    nchk_next  = nchk_reg - mra_pkg::NEW_CW'(1);
                    state_next = mra_pkg::ST_AP_M1;
                end
                else
                begin
                    j_next     = j_reg + mra_pkg::NEW_CW'(1);
                    state_next = mra_pkg::ST_AP_RD;
                end
            end
            mra_pkg::ST_AP_M1:
            begin
                cmd.n_raddr = nchk_reg[mra_pkg::NEW_AW-1:0];
                state_next  = mra_pkg::ST_AP_M2;
            end
            mra_pkg::ST_AP_M2:
            begin
                cmd.n_we   = 1'b1;
                state_next = mra_pkg::ST_AP_M3;
            end
            mra_pkg::ST_AP_M3:
            begin
                cmd.n_raddr = nc_m1[mra_pkg::NEW_AW-1:0];
                state_next  = mra_pkg::ST_AP_M4;
            end
            mra_pkg::ST_AP_M4:
            begin
                cmd.n_we    = 1'b1;
                cmd.n_waddr = nchk_reg[mra_pkg::NEW_AW-1:0];
                nc_next     = nc_m1;
                state_next  = mra_pkg::ST_AP_RD;
            end
            mra_pkg::ST_SPL_MV1:
            begin
                cmd.f_raddr = fc_m1[mra_pkg::FREE_AW-1:0];
                fc_next     = fc_m1;
                state_next  = mra_pkg::ST_SPL_MV2;
            end
            mra_pkg::ST_SPL_MV2:
            begin
                cmd.f_we   = 1'b1;
                cmd.f_wsrc = mra_pkg::FW_MOVE;
                state_next = mra_pkg::ST_SPL_RD;
            end
            mra_pkg::ST_PR_RD:
            begin
                if (i_reg < fc_reg)
                begin
                    state_next = mra_pkg::ST_PR_LD;
                end
                else
                begin
                    j_next     = '0;
                    state_next = mra_pkg::ST_MG_RD;
                end
            end
            mra_pkg::ST_PR_LD:
            begin
                cmd.f_load = 1'b1;
                j_next     = '0;
                state_next = mra_pkg::ST_PR_NRD;
            end
            mra_pkg::ST_PR_NRD:
            begin
                if (j_reg < nc_reg)
                begin
                    state_next = mra_pkg::ST_PR_TST;
                end
                else
                begin
                    i_next     = i_reg + mra_pkg::FREE_CW'(1);
                    state_next = mra_pkg::ST_PR_RD;
                end
            end
            mra_pkg::ST_PR_TST:
            begin
                if (stat.new_in_free)
                begin
                    nc_next    = nc_m1;
                    state_next = mra_pkg::ST_PR_M1;
                end
                else
                begin
                    j_next     = j_reg + mra_pkg::NEW_CW'(1);
                    state_next = mra_pkg::ST_PR_NRD;
                end
            end
            mra_pkg::ST_PR_M1:
            begin
                cmd.n_raddr = nc_reg[mra_pkg::NEW_AW-1:0];
                state_next  = mra_pkg::ST_PR_M2;
            end
            mra_pkg::ST_PR_M2:
            begin
                cmd.n_we   = 1'b1;
                state_next = mra_pkg::ST_PR_NRD;
            end
            mra_pkg::ST_MG_RD:
            begin
                if (j_reg < nc_reg)
                begin
                    state_next = mra_pkg::ST_MG_WR;
                end
                else
                begin
                    nc_next    = '0;
                    state_next = mra_pkg::ST_DONE;
                end
            end
            mra_pkg::ST_MG_WR:
            begin
                if (fc_reg < mra_pkg::FREE_CW'(mra_pkg::MAX_FREE_RECTS))
                begin
                    cmd.f_we    = 1'b1;
                    cmd.f_waddr = fc_reg[mra_pkg::FREE_AW-1:0];
                    cmd.f_wsrc  = mra_pkg::FW_NEW;
                    fc_next     = fc_reg + mra_pkg::FREE_CW'(1);
                end
                else
                begin
                    dropped_next = 1'b1;
                end
                j_next     = j_reg + mra_pkg::NEW_CW'(1);
                state_next = mra_pkg::ST_MG_RD;
            end
            mra_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    res.push   = 1'b1;
                    state_next = mra_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mra_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

### rtl/core/maxrects_rect_allocator_top.sv
// ----------------------------------------------------------------------------
// maxrects_rect_allocator_top
// maxrects bin packer: apb registers, sequencer, datapath, result register
// ----------------------------------------------------------------------------
//  channel | signals                                   | beat
//  apb     | psel penable pwrite paddr pwdata prdata   | write on access phase
//  in      | in_valid in_ready cmd rect_width/height   | one command
//  out     | out_valid out_ready placed pos_x/y ovf    | one result
//
//  clear rewrites the full-bin entry; a place runs the scan plus the split,
//  prune (F*N reads) and merge passes, F free and N new rectangles
//  the free rectangle memory port sets the rate: one entry read per step
//  after reset the init state writes the full-bin entry before the first beat
//  a result waits in the output register; the next command is taken meanwhile
module maxrects_rect_allocator_top (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [mra_pkg::CFG_AW-1:0]     paddr,
    input  logic [mra_pkg::APB_DW-1:0]     pwdata,
    output logic [mra_pkg::APB_DW-1:0]     prdata,
    output logic                           pready,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           cmd,
    input  logic [mra_pkg::DIM_W-1:0]      rect_width,
    input  logic [mra_pkg::DIM_W-1:0]      rect_height,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic                           placed,
    output logic [mra_pkg::POS_W-1:0]      pos_x,
    output logic [mra_pkg::POS_W-1:0]      pos_y,
    output logic                           store_overflow
);

    logic [mra_pkg::DIM_W-1:0]  bin_width_reg;
    logic [mra_pkg::DIM_W-1:0]  bin_height_reg;
    logic [mra_pkg::RULE_W-1:0] fit_rule_reg;
    logic                       out_valid_reg;
    logic                       placed_reg;
    logic [mra_pkg::POS_W-1:0]  pos_x_reg;
    logic [mra_pkg::POS_W-1:0]  pos_y_reg;
    logic                       overflow_reg;
    logic                       cfg_write;
    logic                       out_free;

    mra_pkg::ctrl_cmd_t ctl_cmd;
    mra_pkg::dp_stat_t  dp_stat;
    mra_pkg::res_t      res;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign out_free  = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bin_width_reg  <= mra_pkg::BIN_RESET;
            bin_height_reg <= mra_pkg::BIN_RESET;
            fit_rule_reg   <= mra_pkg::RULE_AREA;
        end
        else if (cfg_write)
        begin
            unique case (mra_pkg::reg_idx_t'(paddr[3:2]))
                mra_pkg::REG_BIN_WIDTH:  bin_width_reg  <= pwdata[mra_pkg::DIM_W-1:0];
                mra_pkg::REG_BIN_HEIGHT: bin_height_reg <= pwdata[mra_pkg::DIM_W-1:0];
                mra_pkg::REG_FIT_RULE:   fit_rule_reg   <= pwdata[mra_pkg::RULE_W-1:0];
                default:                 ;
            endcase
        end
    end

    always_comb
    begin
        unique case (mra_pkg::reg_idx_t'(paddr[3:2]))
            mra_pkg::REG_BIN_WIDTH:  prdata = mra_pkg::APB_DW'(bin_width_reg);
            mra_pkg::REG_BIN_HEIGHT: prdata = mra_pkg::APB_DW'(bin_height_reg);
            mra_pkg::REG_FIT_RULE:   prdata = mra_pkg::APB_DW'(fit_rule_reg);
            default:                 prdata = '0;
        endcase
    end

    mra_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_cmd    (cmd),
        .in_h_zero (rect_height == '0),
        .out_free  (out_free),
        .stat      (dp_stat),
        .in_ready  (in_ready),
        .cmd       (ctl_cmd),
        .res       (res)
    );

    mra_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (ctl_cmd),
        .rect_width  (rect_width),
        .rect_height (rect_height),
        .bin_width   (bin_width_reg),
        .bin_height  (bin_height_reg),
        .fit_rule    (fit_rule_reg),
        .stat        (dp_stat)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res.push)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res.push)
        begin
            placed_reg   <= res.placed;
            pos_x_reg    <= res.placed ? dp_stat.best_x[mra_pkg::POS_W-1:0] : '0;
            pos_y_reg    <= res.placed ? dp_stat.best_y[mra_pkg::POS_W-1:0] : '0;
            overflow_reg <= res.placed && res.overflow;
        end
    end

    assign out_valid      = out_valid_reg;
    assign placed         = placed_reg;
    assign pos_x          = pos_x_reg;
    assign pos_y          = pos_y_reg;
    assign store_overflow = overflow_reg;

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        res.push |-> (!out_valid_reg || out_ready))
        else $error("result pushed over a waiting beat");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("ready held after accepting a beat");

    a_unplaced_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !placed) |-> (pos_x == '0 && pos_y == '0 && !store_overflow))
        else $error("unplaced result carries position or overflow");

endmodule
